// File: sv/sss_pkg.sv
// shared types and constants for the sample set statistics block
// no dependencies
package sss_pkg;

  localparam int CAPACITY    = 256;
  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int BIT_W       = $clog2(SAMPLE_BITS);
  localparam int SUM_W       = 32;
  localparam int SQ_W        = 56;
  localparam int STEP_W      = $clog2(SQ_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_REPORT = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [23:0] sample;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [8:0]  count;
    logic [31:0] total;
    logic [23:0] mean_value;
    logic [47:0] variance_value;
    logic [23:0] median_value;
    logic [23:0] spread;
  } out_item_t;

  typedef struct packed {
    logic                   en;
    logic [ADDR_W-1:0]      addr;
    logic [SAMPLE_BITS-1:0] data;
  } mem_wr_t;

endpackage

// File: sv/sample_set_statistics.sv
// sample_set_statistics: collects unsigned samples and reports count, sum,
// mean, variance, median and spread of the samples held.
//
// in channel (in_valid/in_ready/in_data): operation add appends the sample,
// operation report asks for the statistics. out channel carries one result
// item per input item, in order. items pass a two-entry queue into the
// executor, so the input keeps flowing while a result waits in the output
// register.
// an add is held in the queue, then its result is registered in the output
// register; adds sustain one item per cycle while the receiver keeps up.
// a report walks the sample store once per result bit to find the median, one
// read a cycle from the single read port, while the serial divider forms the
// mean and variance; the result is registered once both have finished.
// an add to a full store drops the sample and flags it; a report on an empty
// set flags an error at once.
// reset clears the count, the sums and the queue; the store needs no clearing.
// a stalled receiver holds the output register and then the queue, and
// in_ready falls once the queue is full.
// depends on sss_pkg, sss_front, sss_back
module sample_set_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sss_pkg::out_item_t out_data
);

  logic              q_valid;
  logic              q_ready;
  sss_pkg::in_item_t q_data;

  sss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  sss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // an added sample always leaves at least one sample held
  a_added_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sss_pkg::ST_ADDED |-> out_data.count != '0)
    else $error("add result with zero count");

  // empty report carries nothing
  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sss_pkg::ST_EMPTY |->
      out_data.count == '0 && out_data.total == '0)
    else $error("empty report with data");

  // a valid report has samples and a mean no larger than the sum
  a_report_sane : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sss_pkg::ST_REPORT |->
      out_data.count != '0 && out_data.mean_value <= out_data.total)
    else $error("inconsistent report");

  // the executor never takes an item from the queue while it sees no room downstream
  a_no_pop_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready |-> !out_valid || out_ready)
    else $error("item started with output register blocked");
`endif

endmodule

// File: sv/sss_front.sv
// front end: small item queue between the input channel and the executor
// depends on sss_pkg
module sss_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sss_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output sss_pkg::in_item_t q_data
);

  sss_pkg::in_item_t                 buf_r [sss_pkg::QUEUE_DEPTH];
  logic [sss_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [sss_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [sss_pkg::QCNT_W-1:0]        cnt_r;
  logic                              push;
  logic                              pop;

  assign in_ready = cnt_r != sss_pkg::QCNT_W'(sss_pkg::QUEUE_DEPTH);
  assign q_valid  = cnt_r != '0;
  assign q_data   = buf_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: sv/sss_div.sv
// serial restoring divider, one quotient bit per cycle for sum and square sum
// depends on sss_pkg
module sss_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sss_pkg::SUM_W-1:0] sum_in,
  input  logic [sss_pkg::SQ_W-1:0]  sq_in,
  input  logic [sss_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [sss_pkg::SUM_W-1:0] quot_sum,
  output logic [sss_pkg::SQ_W-1:0]  quot_sq
);

  logic [sss_pkg::SQ_W-1:0]   a_r;
  logic [sss_pkg::SQ_W-1:0]   b_r;
  logic [sss_pkg::CNT_W-1:0]  ra_r;
  logic [sss_pkg::CNT_W-1:0]  rb_r;
  logic [sss_pkg::CNT_W-1:0]  d_r;
  logic [sss_pkg::STEP_W-1:0] step_r;
  logic                       run_r;
  logic                       done_r;
  logic [sss_pkg::CNT_W:0]    ta;
  logic [sss_pkg::CNT_W:0]    tb;
  logic                       ge_a;
  logic                       ge_b;

  // shift in the next dividend bit, subtract if it fits
  assign ta   = {ra_r, a_r[sss_pkg::SQ_W-1]};
  assign tb   = {rb_r, b_r[sss_pkg::SQ_W-1]};
  assign ge_a = ta >= {1'b0, d_r};
  assign ge_b = tb >= {1'b0, d_r};

  assign done     = done_r;
  assign quot_sum = a_r[sss_pkg::SUM_W-1:0];
  assign quot_sq  = b_r;

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= sss_pkg::SQ_W'(sum_in);
      b_r  <= sq_in;
      ra_r <= '0;
      rb_r <= '0;
      d_r  <= divisor;
    end else if (run_r) begin
      a_r  <= {a_r[sss_pkg::SQ_W-2:0], ge_a};
      b_r  <= {b_r[sss_pkg::SQ_W-2:0], ge_b};
      ra_r <= sss_pkg::CNT_W'(ge_a ? ta - {1'b0, d_r} : ta);
      rb_r <= sss_pkg::CNT_W'(ge_b ? tb - {1'b0, d_r} : tb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      step_r <= '0;
      run_r  <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == sss_pkg::STEP_W'(sss_pkg::SQ_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// File: sv/sss_median.sv
// sample store and median search, one result bit per scan of the store
// depends on sss_pkg
module sss_median (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sss_pkg::mem_wr_t                wr,
  input  logic                            start,
  input  logic [sss_pkg::CNT_W-1:0]       n,
  output logic                            done,
  output logic [sss_pkg::SAMPLE_BITS-1:0] median
);

  logic [sss_pkg::SAMPLE_BITS-1:0] mem_r [sss_pkg::CAPACITY];
  logic [sss_pkg::SAMPLE_BITS-1:0] rd_data_r;
  logic [sss_pkg::SAMPLE_BITS-1:0] prefix_r;
  logic [sss_pkg::ADDR_W-1:0]      idx_r;
  logic [sss_pkg::ADDR_W-1:0]      last_idx_r;
  logic [sss_pkg::BIT_W-1:0]       bit_r;
  logic [sss_pkg::CNT_W-1:0]       cnt_r;
  logic [sss_pkg::CNT_W-1:0]       k_r;
  logic                            issue_r;
  logic                            rv_r;
  logic                            rlast_r;
  logic                            done_r;
  logic [sss_pkg::SAMPLE_BITS-1:0] hi_mask;
  logic                            match;
  logic [sss_pkg::CNT_W-1:0]       tot;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_data_r <= mem_r[idx_r];
  end

  // element agrees with the prefix above the current bit and has a zero there
  assign hi_mask = ~((sss_pkg::SAMPLE_BITS'(2) << bit_r) - sss_pkg::SAMPLE_BITS'(1));
  assign match   = (((rd_data_r ^ prefix_r) & hi_mask) == '0) && !rd_data_r[bit_r];
  assign tot     = cnt_r + sss_pkg::CNT_W'(match);
  assign done    = done_r;
  assign median  = prefix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      rv_r    <= 1'b0;
      rlast_r <= 1'b0;
      done_r  <= 1'b0;
    end else if (start) begin
      bit_r      <= sss_pkg::BIT_W'(sss_pkg::SAMPLE_BITS - 1);
      idx_r      <= '0;
      issue_r    <= 1'b1;
      rv_r       <= 1'b0;
      rlast_r    <= 1'b0;
      k_r        <= n >> 1;
      last_idx_r <= sss_pkg::ADDR_W'(n - 1'b1);
      prefix_r   <= '0;
      cnt_r      <= '0;
      done_r     <= 1'b0;
    end else begin
      rv_r    <= issue_r;
      rlast_r <= issue_r && (idx_r == last_idx_r);
      if (issue_r) begin
        if (idx_r == last_idx_r) begin
          issue_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (rv_r) begin
        if (rlast_r) begin
          cnt_r <= '0;
          if (k_r >= tot) begin
            prefix_r <= prefix_r | (sss_pkg::SAMPLE_BITS'(1) << bit_r);
            k_r      <= k_r - tot;
          end
          if (bit_r == '0) begin
            done_r <= 1'b1;
          end else begin
            bit_r   <= bit_r - 1'b1;
            idx_r   <= '0;
            issue_r <= 1'b1;
          end
        end else begin
          cnt_r <= tot;
        end
      end
    end
  end

endmodule

// File: sv/sss_back.sv
// back end: running sums, extremes, report sequencing and output register
// depends on sss_pkg, sss_div, sss_median
module sss_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  sss_pkg::in_item_t  q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sss_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_FIN
  } state_t;

  localparam int SQR_W = 2 * sss_pkg::SAMPLE_BITS;
  localparam int M2_W  = 2 * sss_pkg::SUM_W;

  state_t                          state_r;
  logic [sss_pkg::CNT_W-1:0]       held_r;
  logic [sss_pkg::SUM_W-1:0]       sum_r;
  logic [sss_pkg::SQ_W-1:0]        sq_r;
  logic [sss_pkg::SAMPLE_BITS-1:0] min_r;
  logic [sss_pkg::SAMPLE_BITS-1:0] max_r;
  logic [M2_W-1:0]                 mean2_r;
  logic                            out_valid_r;
  sss_pkg::out_item_t              out_r;

  logic                            out_free;
  logic                            take;
  logic                            is_full;
  logic [sss_pkg::SAMPLE_BITS-1:0] s;
  logic [SQR_W-1:0]                sqr;
  logic [sss_pkg::SUM_W:0]         sum_add;
  logic [sss_pkg::SQ_W:0]          sq_add;
  logic [sss_pkg::SUM_W-1:0]       sum_nxt;
  logic [sss_pkg::SQ_W-1:0]        sq_nxt;
  logic                            start;
  sss_pkg::mem_wr_t                wr;
  logic                            div_done;
  logic [sss_pkg::SUM_W-1:0]       mean;
  logic [sss_pkg::SQ_W-1:0]        msq;
  logic                            med_done;
  logic [sss_pkg::SAMPLE_BITS-1:0] med;
  logic [M2_W-1:0]                 var_full;
  logic [sss_pkg::SAMPLE_BITS-1:0] rng;
  logic [sss_pkg::SAMPLE_BITS-1:0] mean_lo;
  logic                            load_out;
  logic                            out_valid_nxt;
  sss_pkg::out_item_t              out_nxt;

  assign out_free = !out_valid_r || out_ready;
  assign q_ready  = (state_r == S_IDLE) && out_free;
  assign take     = q_valid && q_ready;
  assign is_full  = held_r == sss_pkg::CNT_W'(sss_pkg::CAPACITY);
  assign s        = sss_pkg::SAMPLE_BITS'(q_data.sample);
  assign sqr      = SQR_W'(s) * SQR_W'(s);
  assign sum_add  = {1'b0, sum_r} + (sss_pkg::SUM_W + 1)'(s);
  assign sq_add   = {1'b0, sq_r} + (sss_pkg::SQ_W + 1)'(sqr);
  assign sum_nxt  = sum_add[sss_pkg::SUM_W] ? '1 : sum_add[sss_pkg::SUM_W-1:0];
  assign sq_nxt   = sq_add[sss_pkg::SQ_W] ? '1 : sq_add[sss_pkg::SQ_W-1:0];

  assign start   = take && (q_data.operation == sss_pkg::OP_REPORT) && (held_r != '0);
  assign wr.en   = take && (q_data.operation == sss_pkg::OP_ADD) && !is_full;
  assign wr.addr = held_r[sss_pkg::ADDR_W-1:0];
  assign wr.data = s;

  // the mean never exceeds the largest sample, so its low bits carry it all
  assign mean_lo  = mean[sss_pkg::SAMPLE_BITS-1:0];
  assign var_full = (M2_W'(msq) > mean2_r) ? M2_W'(msq) - mean2_r : '0;
  assign rng      = max_r - min_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    load_out = 1'b0;
    out_nxt  = '0;
    case (state_r)
      S_IDLE: begin
        if (take && !start) begin
          load_out = 1'b1;
          if (q_data.operation == sss_pkg::OP_ADD) begin
            if (is_full) begin
              out_nxt.status = sss_pkg::ST_FULL;
              out_nxt.count  = 9'(held_r);
              out_nxt.total  = 32'(sum_r);
            end else begin
              out_nxt.status = sss_pkg::ST_ADDED;
              out_nxt.count  = 9'(held_r + 1'b1);
              out_nxt.total  = 32'(sum_nxt);
            end
          end else begin
            out_nxt.status = sss_pkg::ST_EMPTY;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          load_out               = 1'b1;
          out_nxt.status         = sss_pkg::ST_REPORT;
          out_nxt.count          = 9'(held_r);
          out_nxt.total          = 32'(sum_r);
          out_nxt.mean_value     = (mean > 24'hFFFFFF) ? 24'hFFFFFF : 24'(mean);
          out_nxt.variance_value = (var_full > 48'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF
                                                                 : 48'(var_full);
          out_nxt.median_value   = (med > 24'hFFFFFF) ? 24'hFFFFFF : 24'(med);
          out_nxt.spread         = (rng > 24'hFFFFFF) ? 24'hFFFFFF : 24'(rng);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

  sss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .sum_in   (sum_r),
    .sq_in    (sq_r),
    .divisor  (held_r),
    .done     (div_done),
    .quot_sum (mean),
    .quot_sq  (msq)
  );

  sss_median u_median (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .start  (start),
    .n      (held_r),
    .done   (med_done),
    .median (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        out_r <= out_nxt;
      end
      case (state_r)
        S_IDLE: begin
          if (take) begin
            if (q_data.operation == sss_pkg::OP_ADD) begin
              if (!is_full) begin
                held_r <= held_r + 1'b1;
                sum_r  <= sum_nxt;
                sq_r   <= sq_nxt;
                if (held_r == '0 || s < min_r) begin
                  min_r <= s;
                end
                if (held_r == '0 || s > max_r) begin
                  max_r <= s;
                end
              end
            end else if (held_r != '0) begin
              state_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (div_done && med_done) begin
            mean2_r <= M2_W'(SQR_W'(mean_lo) * SQR_W'(mean_lo));
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/testbench.sv
// testbench for sample_set_statistics: directed table, fill to capacity, then random add/report items
// checks every result against a behavioral predictor; depends on sss_pkg and the rtl
module testbench;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sss_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sss_pkg::out_item_t out_data;

  sample_set_statistics dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [23:0]        held [$];
  logic [31:0]        sum_acc;
  logic [55:0]        sq_acc;
  sss_pkg::out_item_t pending_stats [$];
  int                 errors = 0;
  int                 cycles = 0;
  localparam int CYCLE_LIMIT = 40000000;

  function automatic logic [47:0] sat48(logic [63:0] v);
    return (v > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
  endfunction

  function automatic sss_pkg::out_item_t compute_stats(sss_pkg::in_item_t it);
    sss_pkg::out_item_t r;
    logic [23:0] sorted [$];
    logic [63:0] n, mean, msq, m2, var_v, s64, ssum;
    r = '0;
    if (it.operation == sss_pkg::OP_ADD) begin
      if (held.size() >= sss_pkg::CAPACITY) begin
        r.status = sss_pkg::ST_FULL;
      end else begin
        held = {held, it.sample};
        s64 = {40'd0, it.sample};
        ssum = {32'd0, sum_acc} + s64;
        sum_acc = (ssum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ssum[31:0];
        ssum = {8'd0, sq_acc} + s64 * s64;
        sq_acc = (ssum > 64'h00FF_FFFF_FFFF_FFFF) ? '1 : ssum[55:0];
        r.status = sss_pkg::ST_ADDED;
      end
      r.count = 9'(held.size());
      r.total = sum_acc;
    end else if (held.size() == 0) begin
      r.status = sss_pkg::ST_EMPTY;
    end else begin
      n = 64'(held.size());
      mean = sum_acc / n;
      msq = sq_acc / n;
      m2 = mean * mean;
      var_v = (msq > m2) ? msq - m2 : 64'd0;
      sorted = held;
      sorted.sort();
      r.status = sss_pkg::ST_REPORT;
      r.count = n[8:0];
      r.total = sum_acc;
      r.mean_value = (mean > 64'hFF_FFFF) ? 24'hFF_FFFF : mean[23:0];
      r.variance_value = sat48(var_v);
      r.median_value = sorted[n / 2];
      r.spread = sorted[n - 1] - sorted[0];
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result checker and receiver stalls
  int stall_left = 0;
  bit quiet_recv = 0;
  always @(posedge clk) begin
    sss_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t unexpected item actual %p", $time, out_data);
      end else begin
        e = pending_stats.pop_front();
        if (out_data.status !== e.status)
          $display("%0t status exp %0d act %0d", $time, e.status, out_data.status);
        if (out_data.count !== e.count)
          $display("%0t count exp %0d act %0d", $time, e.count, out_data.count);
        if (out_data.total !== e.total)
          $display("%0t total exp %0d act %0d", $time, e.total, out_data.total);
        if (out_data.mean_value !== e.mean_value)
          $display("%0t mean exp %0d act %0d", $time, e.mean_value, out_data.mean_value);
        if (out_data.variance_value !== e.variance_value)
          $display("%0t variance exp %0d act %0d", $time, e.variance_value,
                   out_data.variance_value);
        if (out_data.median_value !== e.median_value)
          $display("%0t median exp %0d act %0d", $time, e.median_value,
                   out_data.median_value);
        if (out_data.spread !== e.spread)
          $display("%0t spread exp %0d act %0d", $time, e.spread, out_data.spread);
        if (out_data !== e) errors++;
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet_recv) stall_left <= gap_len();
    end
  end

  // directed rows: expected typed only where obvious, else predictor
  typedef struct {
    sss_pkg::in_item_t  item;
    bit                 typed;
    sss_pkg::out_item_t want;
  } row_t;
  row_t rows [$];

  // valid stays up into the next item when no gap follows
  task automatic send(sss_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic row_t mk(logic op, logic [23:0] s, bit typed, sss_pkg::out_item_t w);
    row_t r;
    r.item.operation = op;
    r.item.sample = s;
    r.typed = typed;
    r.want = w;
    return r;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    idle_cycles(40);
  endtask

  task automatic reset_model();
    held.delete();
    sum_acc = '0;
    sq_acc = '0;
  endtask

  initial begin
    sss_pkg::out_item_t w, p;
    sss_pkg::in_item_t it;
    int n_items, run_len, sizes;
    bit quiet_send;
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    w = '0; w.status = sss_pkg::ST_EMPTY;
    rows = {rows, mk(sss_pkg::OP_REPORT, 24'h0, 1, w)};
    w = '0; w.status = sss_pkg::ST_ADDED; w.count = 1; w.total = 32'hFF_FFFF;
    rows = {rows, mk(sss_pkg::OP_ADD, 24'hFF_FFFF, 1, w)};
    w.status = sss_pkg::ST_REPORT; w.mean_value = 24'hFF_FFFF; w.median_value = 24'hFF_FFFF;
    rows = {rows, mk(sss_pkg::OP_REPORT, 24'h5A5A5A, 1, w)};
    w = '0; w.status = sss_pkg::ST_ADDED; w.count = 2; w.total = 32'hFF_FFFF;
    rows = {rows, mk(sss_pkg::OP_ADD, 24'h0, 1, w)};
    rows = {rows, mk(sss_pkg::OP_REPORT, 24'hFF_FFFF, 0, w)};
    rows = {rows, mk(sss_pkg::OP_ADD, 24'h00_0001, 0, w)};
    rows = {rows, mk(sss_pkg::OP_ADD, 24'h80_0000, 0, w)};
    rows = {rows, mk(sss_pkg::OP_ADD, 24'h55_5555, 0, w)};
    rows = {rows, mk(sss_pkg::OP_REPORT, 24'h0, 0, w)};
    rows = {rows, mk(sss_pkg::OP_REPORT, 24'h0, 0, w)};
    rows = {rows, mk(sss_pkg::OP_ADD, 24'hAA_AAAA, 0, w)};
    rows = {rows, mk(sss_pkg::OP_REPORT, 24'h0, 0, w)};

    quiet_send = 0;
    foreach (rows[i]) begin
      p = compute_stats(rows[i].item);
      if (rows[i].typed && p !== rows[i].want) begin
        errors++;
        $display("%0t table row %0d exp %p predictor %p", $time, i, rows[i].want, p);
      end
      pending_stats = {pending_stats, (rows[i].typed ? rows[i].want : p)};
      send(rows[i].item);
      idle_cycles(gap_len());
    end

    // fill to capacity with near-max samples, then overflow adds and a report
    while (held.size() < sss_pkg::CAPACITY) begin
      it.operation = sss_pkg::OP_ADD;
      it.sample = 24'(24'hFF_FFFF - $urandom_range(0, 3));
      pending_stats = {pending_stats, compute_stats(it)};
      send(it);
    end
    repeat (3) begin
      it.operation = sss_pkg::OP_ADD; it.sample = 24'($urandom);
      pending_stats = {pending_stats, compute_stats(it)};
      send(it);
    end
    it.operation = sss_pkg::OP_REPORT; it.sample = 0;
    pending_stats = {pending_stats, compute_stats(it)};
    send(it);

    // random part: the store stays full, so adds are dropped and reports see it all
    n_items = 0;
    quiet_recv = 0;
    sizes = 0;
    while (n_items < 1680) begin
      run_len = (sizes % 4 == 0) ? $urandom_range(0, 8) : $urandom_range(0, 2);
      sizes++;
      if (n_items > 900 && n_items < 1300) begin
        quiet_send = 1; quiet_recv = 1;
      end else begin
        quiet_send = 0; quiet_recv = 0;
      end
      repeat (run_len + 1) begin
        it.operation = ($urandom_range(0, 9) < 7) ? sss_pkg::OP_ADD : sss_pkg::OP_REPORT;
        case ($urandom_range(0, 3))
          0: it.sample = 24'($urandom_range(0, 15));
          1: it.sample = 24'(24'hFF_FFFF - $urandom_range(0, 15));
          default: it.sample = 24'($urandom);
        endcase
        pending_stats = {pending_stats, compute_stats(it)};
        send(it);
        n_items++;
        if (!quiet_send) idle_cycles(gap_len());
      end
      it.operation = sss_pkg::OP_REPORT; it.sample = 24'($urandom);
      pending_stats = {pending_stats, compute_stats(it)};
      send(it);
      n_items++;
    end

    quiet_recv = 0;
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
sv/sss_pkg.sv
sv/sss_front.sv
sv/sss_div.sv
sv/sss_median.sv
sv/sss_back.sv
sv/sample_set_statistics.sv
sim/testbench.sv
